>>> rtl/irfe_pkg.sv
package irfe_pkg;

  // Program counter of the microcode table
  localparam int unsigned PcW = 3;
  typedef logic [PcW-1:0] pc_t;

  // Bit pointer into the frame word
  localparam int unsigned IdxW = 5;
  typedef logic [IdxW-1:0] idx_t;

  // Payload widths
  localparam int unsigned FirstW   = 14;
  localparam int unsigned SecondW  = 15;
  localparam int unsigned CarrierW = 16;
  localparam int unsigned WordW    = 32;

  // Protocol codes
  typedef enum logic [2:0] {
    FUNC_NEC     = 3'd0,
    FUNC_NEC_RPT = 3'd1,
    FUNC_SIRC12  = 3'd2,
    FUNC_SIRC20  = 3'd3,
    FUNC_RC5     = 3'd4
  } func_e;

  // Interval lengths in microseconds
  localparam logic [FirstW-1:0]  NecHdrUs     = 14'd9000;
  localparam logic [FirstW-1:0]  NecRptHdrUs  = 14'd4500;
  localparam logic [SecondW-1:0] NecHdrSpUs   = 15'd4500;
  localparam logic [FirstW-1:0]  NecMarkUs    = 14'd560;
  localparam logic [SecondW-1:0] NecZeroSpUs  = 15'd560;
  localparam logic [SecondW-1:0] NecOneSpUs   = 15'd1690;
  localparam logic [FirstW-1:0]  SircStartUs  = 14'd2400;
  localparam logic [FirstW-1:0]  SircZeroUs   = 14'd600;
  localparam logic [FirstW-1:0]  SircOneUs    = 14'd1200;
  localparam logic [SecondW-1:0] SircSpUs     = 15'd600;
  localparam logic [SecondW-1:0] SircGapUs    = 15'd24600;
  localparam logic [FirstW-1:0]  Rc5HalfUs    = 14'd889;
  localparam logic [SecondW-1:0] Rc5HalfSpUs  = 15'd889;

  // Carrier frequencies
  localparam logic [CarrierW-1:0] NecHz  = 16'd38000;
  localparam logic [CarrierW-1:0] SircHz = 16'd40000;
  localparam logic [CarrierW-1:0] Rc5Hz  = 16'd36000;

  // Program entry points
  localparam pc_t EntryNec  = 3'd0;
  localparam pc_t EntrySirc = 3'd3;
  localparam pc_t EntryRc5  = 3'd6;

  // Microword field codes
  typedef enum logic [2:0] {
    FST_HDR,
    FST_560,
    FST_2400,
    FST_SIRC_BIT,
    FST_889
  } fst_sel_e;

  typedef enum logic [2:0] {
    SEC_4500,
    SEC_NEC_BIT,
    SEC_ZERO,
    SEC_600,
    SEC_SIRC_GAP,
    SEC_889
  } sec_sel_e;

  typedef enum logic {
    MK_ONE,
    MK_NOT_BIT
  } mark_sel_e;

  typedef enum logic [1:0] {
    LAST_NONE,
    LAST_ALWAYS,
    LAST_AT_END
  } last_sel_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_LOAD,
    IDX_STEP
  } idx_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP_BIT,
    JMP_LOOP_REP,
    JMP_FINISH
  } jump_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    logic      emit;
    fst_sel_e  fst;
    sec_sel_e  sec;
    mark_sel_e mark;
    last_sel_e last;
    idx_op_e   idx_op;
    jump_e     jump;
    pc_t       target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic      load;
    logic      emit;
    fst_sel_e  fst;
    sec_sel_e  sec;
    mark_sel_e mark;
    last_sel_e last;
    idx_op_e   idx_op;
    logic      rep_dec;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic idx_end;
    logic rep_zero;
  } status_t;

  // Microcode: NEC at 0, SIRC at 3, RC5 at 6
  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    w = '{emit: 1'b0, fst: FST_560, sec: SEC_ZERO, mark: MK_ONE, last: LAST_NONE,
          idx_op: IDX_HOLD, jump: JMP_FINISH, target: '0};
    unique case (pc)
      3'd0: w = '{1'b1, FST_HDR, SEC_4500, MK_ONE, LAST_NONE, IDX_LOAD,
                  JMP_NEXT, 3'd0};
      3'd1: w = '{1'b1, FST_560, SEC_NEC_BIT, MK_ONE, LAST_NONE, IDX_STEP,
                  JMP_LOOP_BIT, 3'd1};
      3'd2: w = '{1'b1, FST_560, SEC_ZERO, MK_ONE, LAST_ALWAYS, IDX_HOLD,
                  JMP_FINISH, 3'd0};
      3'd3: w = '{1'b1, FST_2400, SEC_600, MK_ONE, LAST_NONE, IDX_LOAD,
                  JMP_NEXT, 3'd0};
      3'd4: w = '{1'b1, FST_SIRC_BIT, SEC_SIRC_GAP, MK_ONE, LAST_AT_END,
                  IDX_STEP, JMP_LOOP_BIT, 3'd4};
      3'd5: w = '{1'b0, FST_560, SEC_ZERO, MK_ONE, LAST_NONE, IDX_HOLD,
                  JMP_LOOP_REP, 3'd3};
      3'd6: w = '{1'b1, FST_889, SEC_889, MK_NOT_BIT, LAST_AT_END, IDX_STEP,
                  JMP_LOOP_BIT, 3'd6};
      default: w = '{1'b0, FST_560, SEC_ZERO, MK_ONE, LAST_NONE, IDX_HOLD,
                     JMP_FINISH, 3'd0};
    endcase
    return w;
  endfunction

  function automatic logic func_known(logic [2:0] func);
    return (func == FUNC_NEC) || (func == FUNC_NEC_RPT) || (func == FUNC_SIRC12) ||
           (func == FUNC_SIRC20) || (func == FUNC_RC5);
  endfunction

  function automatic pc_t func_entry(logic [2:0] func);
    pc_t pc;
    pc = EntryNec;
    if ((func == FUNC_SIRC12) || (func == FUNC_SIRC20)) begin
      pc = EntrySirc;
    end else if (func == FUNC_RC5) begin
      pc = EntryRc5;
    end
    return pc;
  endfunction

endpackage

>>> rtl/irfe_sequencer.sv
module irfe_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [2:0]       func_i,
  input  irfe_pkg::status_t status_i,
  output irfe_pkg::ctrl_t  ctrl_o,
  output logic             busy_o
);
  import irfe_pkg::*;

  seq_state_e state_q, state_d;
  pc_t        pc_q, pc_d;
  uword_t     uw;

  // Hold state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  // Fetch the microword, decode jumps, drive the datapath
  always_comb begin
    uw      = ucode_rom(pc_q);
    state_d = state_q;
    pc_d    = pc_q;
    ctrl_o  = '{load: 1'b0, emit: 1'b0, fst: uw.fst, sec: uw.sec, mark: uw.mark,
                last: uw.last, idx_op: IDX_HOLD, rep_dec: 1'b0};
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i && func_known(func_i)) begin
          state_d     = SEQ_RUN;
          pc_d        = func_entry(func_i);
          ctrl_o.load = 1'b1;
        end
      end
      SEQ_RUN: begin
        ctrl_o.emit   = uw.emit;
        ctrl_o.idx_op = uw.idx_op;
        unique case (uw.jump)
          JMP_NEXT: pc_d = pc_q + 1'b1;
          JMP_LOOP_BIT: pc_d = status_i.idx_end ? pc_q + 1'b1 : uw.target;
          JMP_LOOP_REP: begin
            if (status_i.rep_zero) begin
              state_d = SEQ_IDLE;
            end else begin
              pc_d           = uw.target;
              ctrl_o.rep_dec = 1'b1;
            end
          end
          JMP_FINISH: state_d = SEQ_IDLE;
          default: state_d = SEQ_IDLE;
        endcase
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  assign busy_o = (state_q == SEQ_RUN);

endmodule

>>> rtl/irfe_datapath.sv
module irfe_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [2:0]                          func_i,
  input  logic [12:0]                         address_i,
  input  logic [7:0]                          command_i,
  input  irfe_pkg::ctrl_t                     ctrl_i,
  output irfe_pkg::status_t                   status_o,
  output logic                                valid_o,
  output logic                                mark_first_o,
  output logic [irfe_pkg::FirstW-1:0]         first_us_o,
  output logic [irfe_pkg::SecondW-1:0]        second_us_o,
  output logic [irfe_pkg::CarrierW-1:0]       carrier_hz_o,
  output logic                                last_pair_o
);
  import irfe_pkg::*;

  // Request registers
  logic [WordW-1:0]    word_q, word_d;
  logic [FirstW-1:0]   hdr_q, hdr_d;
  logic [CarrierW-1:0] carrier_q, carrier_d;
  idx_t                idx_init_q, idx_init_d;
  idx_t                idx_end_q, idx_end_d;
  logic                dir_up_q, dir_up_d;

  // Working counters
  idx_t                idx_q, idx_d;
  logic [1:0]          rep_q, rep_d;

  // Result register
  logic                valid_q;
  logic                mark_q, last_q;
  logic [FirstW-1:0]   first_q, first_d;
  logic [SecondW-1:0]  second_q, second_d;
  logic                mark_d, last_d;

  logic [7:0] a8;
  logic       bit_cur;
  logic       at_end;

  assign a8       = address_i[7:0];
  assign bit_cur  = word_q[idx_q];
  assign at_end   = (idx_q == idx_end_q);
  assign status_o = '{idx_end: at_end, rep_zero: (rep_q == 2'd0)};

  // Build the frame word and per-protocol settings for a new request; count down repeats
  always_comb begin
    word_d     = word_q;
    hdr_d      = hdr_q;
    carrier_d  = carrier_q;
    idx_init_d = idx_init_q;
    idx_end_d  = idx_end_q;
    dir_up_d   = dir_up_q;
    rep_d      = rep_q;
    if (ctrl_i.load) begin
      unique case (func_i)
        FUNC_NEC, FUNC_NEC_RPT: begin
          if (func_i == FUNC_NEC) begin
            word_d = {a8, ~a8, command_i, ~command_i};
            hdr_d  = NecHdrUs;
          end else begin
            word_d = {a8, a8, command_i, ~command_i};
            hdr_d  = NecRptHdrUs;
          end
          carrier_d  = NecHz;
          idx_init_d = 5'd31;
          idx_end_d  = 5'd0;
          dir_up_d   = 1'b0;
          rep_d      = 2'd0;
        end
        FUNC_SIRC12, FUNC_SIRC20: begin
          if (func_i == FUNC_SIRC12) begin
            word_d    = {20'd0, address_i[4:0], command_i[6:0]};
            idx_end_d = 5'd11;
          end else begin
            word_d    = {12'd0, address_i, command_i[6:0]};
            idx_end_d = 5'd19;
          end
          hdr_d      = NecHdrUs;
          carrier_d  = SircHz;
          idx_init_d = 5'd0;
          dir_up_d   = 1'b1;
          rep_d      = 2'd2;
        end
        default: begin
          word_d     = {18'd0, 2'b11, 1'b0, address_i[4:0], command_i[5:0]};
          hdr_d      = NecHdrUs;
          carrier_d  = Rc5Hz;
          idx_init_d = 5'd13;
          idx_end_d  = 5'd0;
          dir_up_d   = 1'b0;
          rep_d      = 2'd0;
        end
      endcase
    end else if (ctrl_i.rep_dec) begin
      rep_d = rep_q - 2'd1;
    end
  end

  // Advance the bit pointer; preset it with each new request
  always_comb begin
    unique case (ctrl_i.idx_op)
      IDX_LOAD: idx_d = idx_init_q;
      IDX_STEP: idx_d = dir_up_q ? idx_q + 5'd1 : idx_q - 5'd1;
      default:  idx_d = idx_q;
    endcase
    if (ctrl_i.load) begin
      idx_d = idx_init_d;
    end
  end

  // Select the intervals of the current pair
  always_comb begin
    unique case (ctrl_i.fst)
      FST_HDR:      first_d = hdr_q;
      FST_2400:     first_d = SircStartUs;
      FST_SIRC_BIT: first_d = bit_cur ? SircOneUs : SircZeroUs;
      FST_889:      first_d = Rc5HalfUs;
      default:      first_d = NecMarkUs;
    endcase
    unique case (ctrl_i.sec)
      SEC_4500:     second_d = NecHdrSpUs;
      SEC_NEC_BIT:  second_d = bit_cur ? NecOneSpUs : NecZeroSpUs;
      SEC_600:      second_d = SircSpUs;
      SEC_SIRC_GAP: second_d = at_end ? SircGapUs : SircSpUs;
      SEC_889:      second_d = Rc5HalfSpUs;
      default:      second_d = '0;
    endcase
    mark_d = (ctrl_i.mark == MK_NOT_BIT) ? ~bit_cur : 1'b1;
    unique case (ctrl_i.last)
      LAST_ALWAYS: last_d = 1'b1;
      LAST_AT_END: last_d = at_end && (rep_q == 2'd0);
      default:     last_d = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      rep_q   <= '0;
    end else begin
      valid_q <= ctrl_i.emit;
      idx_q   <= idx_d;
      rep_q   <= rep_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    hdr_q      <= hdr_d;
    carrier_q  <= carrier_d;
    idx_init_q <= idx_init_d;
    idx_end_q  <= idx_end_d;
    dir_up_q   <= dir_up_d;
    if (ctrl_i.emit) begin
      mark_q   <= mark_d;
      first_q  <= first_d;
      second_q <= second_d;
      last_q   <= last_d;
    end
  end

  assign valid_o      = valid_q;
  assign mark_first_o = mark_q;
  assign first_us_o   = first_q;
  assign second_us_o  = second_q;
  assign carrier_hz_o = carrier_q;
  assign last_pair_o  = last_q;

endmodule

>>> rtl/ir_remote_frame_encoder_top.sv
// Infrared remote frame encoder: NEC, repeated-address NEC, SIRC-12/20, RC5.
// A request (func_i, address_i, command_i) is taken on a rising edge with
// start high and busy low. Unknown protocol codes are taken and dropped.
// The frame comes out as timing pairs on mark_first_o, first_us_o,
// second_us_o, carrier_hz_o and last_pair_o, each shown for one cycle with
// valid_o high; last_pair_o marks the final pair. The receiver cannot stall,
// so every pair must be taken in the cycle it is shown.
// A microcode sequencer steps one control word per cycle; each word emits
// at most one pair. The request edge moves the sequencer to its run state;
// the first microword is then registered in the result register and shown.
// The pairs follow one per cycle, except for one idle step at the end of
// each of the three SIRC copies and after the RC5 run. Pairs per request:
// NEC 34, SIRC-12 39, SIRC-20 63, RC5 14. For NEC busy falls in the cycle
// the last pair is shown; for SIRC and RC5 it falls in the cycle after. A new
// request may be taken in the first cycle that busy is low.
// Reset returns the sequencer to idle and clears the result strobe.
module ir_remote_frame_encoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    func_i,
  input  logic [12:0]                   address_i,
  input  logic [7:0]                    command_i,
  output logic                          valid_o,
  output logic                          mark_first_o,
  output logic [irfe_pkg::FirstW-1:0]   first_us_o,
  output logic [irfe_pkg::SecondW-1:0]  second_us_o,
  output logic [irfe_pkg::CarrierW-1:0] carrier_hz_o,
  output logic                          last_pair_o
);
  import irfe_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // Step through the program
  irfe_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .func_i   (func_i),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  // Hold the frame word and form the pairs
  irfe_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .address_i    (address_i),
    .command_i    (command_i),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .valid_o      (valid_o),
    .mark_first_o (mark_first_o),
    .first_us_o   (first_us_o),
    .second_us_o  (second_us_o),
    .carrier_hz_o (carrier_hz_o),
    .last_pair_o  (last_pair_o)
  );

endmodule

>>> verif/ir_remote_frame_encoder_checker.sv
module ir_remote_frame_encoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic [12:0] address_i,
  input  logic [7:0]  command_i,
  input  logic        valid_o,
  input  logic        mark_first_o,
  input  logic [13:0] first_us_o,
  input  logic [14:0] second_us_o,
  input  logic [15:0] carrier_hz_o,
  input  logic        last_pair_o,
  output int          fail_count_o,
  output int          pairs_pending_o
);

  // Interval lengths in microseconds and carrier frequencies
  localparam logic [13:0] LeadNecUs     = 14'd9000;
  localparam logic [13:0] LeadNecRptUs  = 14'd4500;
  localparam logic [14:0] LeadNecSpUs   = 15'd4500;
  localparam logic [13:0] BitNecUs      = 14'd560;
  localparam logic [14:0] OneNecSpUs    = 15'd1690;
  localparam logic [14:0] ZeroNecSpUs   = 15'd560;
  localparam logic [14:0] StopNecSpUs   = 15'd0;
  localparam logic [13:0] LeadSircUs    = 14'd2400;
  localparam logic [13:0] OneSircUs     = 14'd1200;
  localparam logic [13:0] ZeroSircUs    = 14'd600;
  localparam logic [14:0] SpSircUs      = 15'd600;
  localparam logic [14:0] TailSircSpUs  = 15'd24600;
  localparam logic [13:0] HalfRc5Us     = 14'd889;
  localparam logic [14:0] HalfRc5SpUs   = 15'd889;
  localparam logic [15:0] CarrierNecHz  = 16'd38000;
  localparam logic [15:0] CarrierSircHz = 16'd40000;
  localparam logic [15:0] CarrierRc5Hz  = 16'd36000;
  localparam int          ReportLimit   = 10;

  typedef struct packed {
    logic        mark_first;
    logic [13:0] first_us;
    logic [14:0] second_us;
    logic [15:0] carrier_hz;
    logic        last_pair;
  } timing_pair_t;

  timing_pair_t expected_pairs[$];
  timing_pair_t seen_pair;
  timing_pair_t want_pair;
  int           n_fail = 0;

  task automatic add_pair(input logic mark, input logic [13:0] a_us,
                          input logic [14:0] b_us, input logic [15:0] hz);
    timing_pair_t p;
    p.mark_first = mark;
    p.first_us   = a_us;
    p.second_us  = b_us;
    p.carrier_hz = hz;
    p.last_pair  = 1'b0;
    expected_pairs = {expected_pairs, p};
  endtask

  // Build the whole frame for one request and queue its timing pairs
  task automatic encode_frame(input logic [2:0] func, input logic [12:0] addr,
                              input logic [7:0] cmd);
    logic [31:0] nec_word;
    logic [19:0] sirc_word;
    logic [13:0] rc5_word;
    int          n_bits;
    int          n_before;
    logic [13:0] lead_us;
    n_before = expected_pairs.size();
    case (func)
      irfe_pkg::FUNC_NEC, irfe_pkg::FUNC_NEC_RPT: begin
        if (func == irfe_pkg::FUNC_NEC) begin
          nec_word = {addr[7:0], ~addr[7:0], cmd, ~cmd};
          lead_us  = LeadNecUs;
        end else begin
          nec_word = {addr[7:0], addr[7:0], cmd, ~cmd};
          lead_us  = LeadNecRptUs;
        end
        add_pair(1'b1, lead_us, LeadNecSpUs, CarrierNecHz);
        for (int i = 31; i >= 0; i--) begin
          add_pair(1'b1, BitNecUs, nec_word[i] ? OneNecSpUs : ZeroNecSpUs, CarrierNecHz);
        end
        add_pair(1'b1, BitNecUs, StopNecSpUs, CarrierNecHz);
      end
      irfe_pkg::FUNC_SIRC12, irfe_pkg::FUNC_SIRC20: begin
        if (func == irfe_pkg::FUNC_SIRC12) begin
          sirc_word = {8'd0, addr[4:0], cmd[6:0]};
          n_bits    = 12;
        end else begin
          sirc_word = {addr, cmd[6:0]};
          n_bits    = 20;
        end
        // Three copies, LSB first, last space of each copy stretched
        for (int rep = 0; rep < 3; rep++) begin
          add_pair(1'b1, LeadSircUs, SpSircUs, CarrierSircHz);
          for (int i = 0; i < n_bits; i++) begin
            add_pair(1'b1, sirc_word[i] ? OneSircUs : ZeroSircUs,
                     (i == n_bits - 1) ? TailSircSpUs : SpSircUs, CarrierSircHz);
          end
        end
      end
      irfe_pkg::FUNC_RC5: begin
        // Two start bits, toggle held at zero, then address and command
        rc5_word = {2'b11, 1'b0, addr[4:0], cmd[5:0]};
        for (int i = 13; i >= 0; i--) begin
          add_pair(~rc5_word[i], HalfRc5Us, HalfRc5SpUs, CarrierRc5Hz);
        end
      end
      default: begin
        // Unknown protocol: drop the request
      end
    endcase
    // Flag the final pair of the request
    if (expected_pairs.size() > n_before) begin
      expected_pairs[expected_pairs.size() - 1].last_pair = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      expected_pairs.delete();
    end else begin
      // Compare each strobed pair with the oldest expected one
      if (valid_o === 1'b1) begin
        seen_pair = {mark_first_o, first_us_o, second_us_o, carrier_hz_o, last_pair_o};
        if (expected_pairs.size() == 0) begin
          n_fail++;
          if (n_fail <= ReportLimit) begin
            $display("%0t: unexpected pair mark=%0d first=%0d second=%0d hz=%0d last=%0d",
                     $realtime, seen_pair.mark_first, seen_pair.first_us,
                     seen_pair.second_us, seen_pair.carrier_hz, seen_pair.last_pair);
          end
        end else begin
          want_pair = expected_pairs.pop_front();
          if (seen_pair.mark_first !== want_pair.mark_first ||
              seen_pair.first_us   !== want_pair.first_us   ||
              seen_pair.second_us  !== want_pair.second_us  ||
              seen_pair.carrier_hz !== want_pair.carrier_hz ||
              seen_pair.last_pair  !== want_pair.last_pair) begin
            n_fail++;
            if (n_fail <= ReportLimit) begin
              $display("%0t: pair mismatch exp mark=%0d first=%0d second=%0d hz=%0d last=%0d",
                       $realtime, want_pair.mark_first, want_pair.first_us,
                       want_pair.second_us, want_pair.carrier_hz, want_pair.last_pair);
              $display("%0t:               got mark=%0d first=%0d second=%0d hz=%0d last=%0d",
                       $realtime, seen_pair.mark_first, seen_pair.first_us,
                       seen_pair.second_us, seen_pair.carrier_hz, seen_pair.last_pair);
            end
          end
        end
      end
      // Predict the frame of each accepted request
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        encode_frame(func_i, address_i, command_i);
      end
    end
    fail_count_o    <= n_fail;
    pairs_pending_o <= expected_pairs.size();
  end

endmodule

>>> verif/tb_ir_remote_frame_encoder_top.sv
module tb_ir_remote_frame_encoder_top;

  // Codes with no protocol behind them
  localparam logic [2:0] FuncRsvdLo  = 3'd5;
  localparam logic [2:0] FuncRsvdHi  = 3'd7;
  localparam int         RandomItems = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  func_i;
  logic [12:0] address_i;
  logic [7:0]  command_i;
  logic        valid_o;
  logic        mark_first_o;
  logic [irfe_pkg::FirstW-1:0]   first_us_o;
  logic [irfe_pkg::SecondW-1:0]  second_us_o;
  logic [irfe_pkg::CarrierW-1:0] carrier_hz_o;
  logic        last_pair_o;
  int          fail_count;
  int          pairs_pending;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ir_remote_frame_encoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .address_i    (address_i),
    .command_i    (command_i),
    .valid_o      (valid_o),
    .mark_first_o (mark_first_o),
    .first_us_o   (first_us_o),
    .second_us_o  (second_us_o),
    .carrier_hz_o (carrier_hz_o),
    .last_pair_o  (last_pair_o)
  );

  ir_remote_frame_encoder_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .func_i          (func_i),
    .address_i       (address_i),
    .command_i       (command_i),
    .valid_o         (valid_o),
    .mark_first_o    (mark_first_o),
    .first_us_o      (first_us_o),
    .second_us_o     (second_us_o),
    .carrier_hz_o    (carrier_hz_o),
    .last_pair_o     (last_pair_o),
    .fail_count_o    (fail_count),
    .pairs_pending_o (pairs_pending)
  );

  // Present one request and hold it until the encoder takes it
  task automatic send_request(input logic [2:0] func, input logic [12:0] addr,
                              input logic [7:0] cmd);
    start     <= 1'b1;
    func_i    <= func;
    address_i <= addr;
    command_i <= cmd;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  // Drop start for a number of cycles
  task automatic idle_for(input int n_cycles);
    start <= 1'b0;
    repeat (n_cycles) @(posedge clk_i);
  endtask

  initial begin
    int          n_sent;
    int          burst_len;
    logic [2:0]  func;
    rst_ni    = 1'b0;
    start     = 1'b0;
    func_i    = '0;
    address_i = '0;
    command_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes on every protocol, back to back
    send_request(irfe_pkg::FUNC_NEC,     13'd0,    8'd0);
    send_request(irfe_pkg::FUNC_NEC,     13'h1FFF, 8'hFF);
    send_request(irfe_pkg::FUNC_NEC_RPT, 13'd0,    8'd0);
    send_request(irfe_pkg::FUNC_NEC_RPT, 13'h1FFF, 8'hFF);
    send_request(irfe_pkg::FUNC_SIRC12,  13'd0,    8'd0);
    send_request(irfe_pkg::FUNC_SIRC12,  13'h1FFF, 8'hFF);
    send_request(irfe_pkg::FUNC_SIRC20,  13'd0,    8'd0);
    send_request(irfe_pkg::FUNC_SIRC20,  13'h1FFF, 8'hFF);
    send_request(irfe_pkg::FUNC_RC5,     13'd0,    8'd0);
    send_request(irfe_pkg::FUNC_RC5,     13'h1FFF, 8'hFF);
    idle_for(7);
    // Alternating bits, with bits above each protocol's width set
    send_request(irfe_pkg::FUNC_NEC,     13'h1EAA, 8'h55);
    send_request(irfe_pkg::FUNC_NEC_RPT, 13'h0155, 8'hAA);
    idle_for(3);
    send_request(irfe_pkg::FUNC_SIRC12,  13'h1AB5, 8'hAA);
    send_request(irfe_pkg::FUNC_SIRC20,  13'h0AAA, 8'hD5);
    send_request(irfe_pkg::FUNC_RC5,     13'h1F0A, 8'hD5);
    send_request(irfe_pkg::FUNC_RC5,     13'h0015, 8'h2A);
    // Unknown protocols are taken and dropped
    for (int code = FuncRsvdLo; code <= FuncRsvdHi; code++) begin
      send_request(code[2:0], 13'($urandom), 8'($urandom));
    end
    send_request(irfe_pkg::FUNC_NEC, 13'h00C3, 8'h3C);
    idle_for(40);

    // Random bursts with random gaps; a few unknown codes mixed in
    n_sent = 0;
    while (n_sent < RandomItems) begin
      burst_len = $urandom_range(1, 6);
      repeat (burst_len) begin
        if ($urandom_range(0, 9) == 0) begin
          func = 3'($urandom_range(FuncRsvdLo, FuncRsvdHi));
        end else begin
          func = 3'($urandom_range(irfe_pkg::FUNC_NEC, irfe_pkg::FUNC_RC5));
          n_sent++;
        end
        send_request(func, 13'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_for($urandom_range(1, 80));
      end
    end

    // Drain and watch for stray pairs
    start <= 1'b0;
    while (pairs_pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && pairs_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Bound the run well past the slowest legal schedule
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/irfe_pkg.sv
rtl/irfe_sequencer.sv
rtl/irfe_datapath.sv
rtl/ir_remote_frame_encoder_top.sv
verif/ir_remote_frame_encoder_checker.sv
verif/tb_ir_remote_frame_encoder_top.sv
